[sv/bba_pkg.sv]
package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    localparam int LIMIT_W  = 13;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_READ   = 3'b010,
        S_MODIFY = 3'b100
    } state_t;

endpackage

[sv/bitmap_block_allocator.sv]
// First-fit bitmap block allocator. Each request passes through accept with word
// lookup (a priority encoder over per-word full flags for allocate, a constant
// reciprocal multiply for free), a read of the map RAM, and a modify and write-back
// cycle that also loads the result register: a single read-modify-write of the map
// RAM. A new request is taken while a result still waits on rsp_stall; the block
// holds in the write-back cycle only while the result register is still occupied and
// rsp_stall is high. After reset the map reads as all clear through per-word valid
// flags, so there is no clearing pass. Write block_limit only while no request is in
// flight; values above MAX_BLOCKS act as MAX_BLOCKS.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         limit_write,
    input  logic [bba_pkg::LIMIT_W-1:0]  block_limit,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         opcode,
    input  logic [bba_pkg::INDEX_W-1:0]  block_index,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [bba_pkg::INDEX_W-1:0]  granted_index,
    output logic [bba_pkg::STATUS_W-1:0] status,
    output logic [bba_pkg::COUNT_W-1:0]  used_total
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int LIM_W     = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W     = (LIM_W > bba_pkg::LIMIT_W) ? LIM_W : bba_pkg::LIMIT_W;
    localparam int XW        = CMP_W + 1;
    localparam int Q_SH      = bba_pkg::INDEX_W + BIT_W;
    localparam int QP_W      = bba_pkg::INDEX_W + Q_SH + 2;
    localparam longint RECIP = ((64'd1 << Q_SH) + WORD_BITS - 1) / WORD_BITS;

    bba_pkg::state_t               state_reg, state_next;
    bba_pkg::opcode_t              op_reg;
    logic [bba_pkg::INDEX_W-1:0]   idx_reg;
    logic [WADDR_W-1:0]            word_reg;
    logic                          found_reg;
    logic                          range_bad_reg;
    logic [XW-1:0]                 base_reg;
    logic [MAP_WORDS-1:0]          full_reg;
    logic [MAP_WORDS-1:0]          valid_reg;
    logic [bba_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [bba_pkg::LIMIT_W-1:0]   limit_reg;
    logic                          rsp_valid_reg;
    logic [bba_pkg::INDEX_W-1:0]   granted_reg, granted_next;
    bba_pkg::status_t              status_reg, status_next;
    logic [bba_pkg::COUNT_W-1:0]   used_reg;

    logic [CMP_W-1:0]              lim_eff;
    logic                          accept;
    logic                          proceed;
    logic [WADDR_W-1:0]            sel_word;
    logic                          sel_found;
    logic [QP_W-1:0]               q_prod;
    logic [WORD_BITS-1:0]          ram_rdata;
    logic [WORD_BITS-1:0]          rd_word;
    logic [WORD_BITS-1:0]          new_word;
    logic [BIT_W-1:0]              clr_bit;
    logic [BIT_W-1:0]              free_bit;
    logic [XW-1:0]                 free_off;
    logic [XW-1:0]                 alloc_idx;
    logic                          alloc_ok;
    logic                          free_hit;
    logic                          wr_en;

    always_comb
    begin
        if (CMP_W'(limit_reg) > CMP_W'(MAX_BLOCKS))
        begin
            lim_eff = CMP_W'(MAX_BLOCKS);
        end
        else
        begin
            lim_eff = CMP_W'(limit_reg);
        end
    end

    assign req_stall = (state_reg != bba_pkg::S_IDLE);
    assign accept    = req_valid && (state_reg == bba_pkg::S_IDLE);
    assign proceed   = (state_reg == bba_pkg::S_MODIFY) && (!rsp_valid_reg || !rsp_stall);

    // pick the lowest word that is not full and starts below the limit
    always_comb
    begin
        sel_word  = '0;
        sel_found = 1'b0;
        for (int w = MAP_WORDS - 1; w >= 0; w--)
        begin
            if (!full_reg[w] && (CMP_W'(w * WORD_BITS) < lim_eff))
            begin
                sel_word  = WADDR_W'(w);
                sel_found = 1'b1;
            end
        end
    end

    assign q_prod = QP_W'(block_index) * QP_W'(RECIP);

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (wr_en),
        .waddr (word_reg),
        .wdata (new_word),
        .re    (state_reg == bba_pkg::S_READ),
        .raddr (word_reg),
        .rdata (ram_rdata)
    );

    assign rd_word = valid_reg[word_reg] ? ram_rdata : '0;

    always_comb
    begin
        clr_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!rd_word[b])
            begin
                clr_bit = BIT_W'(b);
            end
        end
    end

    assign alloc_idx = base_reg + XW'(clr_bit);
    assign alloc_ok  = found_reg && (alloc_idx < XW'(lim_eff));
    assign free_off  = XW'(idx_reg) - base_reg;
    assign free_bit  = free_off[BIT_W-1:0];
    assign free_hit  = !range_bad_reg && rd_word[free_bit];

    always_comb
    begin
        new_word     = rd_word;
        count_next   = count_reg;
        granted_next = '0;
        status_next  = bba_pkg::ST_OK;
        wr_en        = 1'b0;
        case (op_reg)
            bba_pkg::OP_ALLOC:
            begin
                new_word = rd_word | (WORD_BITS'(1) << clr_bit);
                if (alloc_ok)
                begin
                    wr_en        = proceed;
                    count_next   = count_reg + 1'b1;
                    granted_next = alloc_idx[bba_pkg::INDEX_W-1:0];
                end
                else
                begin
                    status_next = bba_pkg::ST_FULL;
                end
            end
            bba_pkg::OP_FREE:
            begin
                new_word = rd_word & ~(WORD_BITS'(1) << free_bit);
                if (range_bad_reg)
                begin
                    status_next = bba_pkg::ST_RANGE;
                end
                else if (free_hit)
                begin
                    wr_en = proceed;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                new_word = rd_word;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = bba_pkg::S_READ;
                end
            end
            bba_pkg::S_READ:
            begin
                state_next = bba_pkg::S_MODIFY;
            end
            bba_pkg::S_MODIFY:
            begin
                if (proceed)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::S_IDLE;
            full_reg      <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            limit_reg     <= bba_pkg::LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (limit_write)
            begin
                limit_reg <= block_limit;
            end
            if (wr_en)
            begin
                full_reg[word_reg]  <= &new_word;
                valid_reg[word_reg] <= 1'b1;
            end
            if (proceed)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= bba_pkg::opcode_t'(opcode);
            idx_reg       <= block_index;
            found_reg     <= sel_found;
            range_bad_reg <= XW'(block_index) >= XW'(lim_eff);
            if (opcode == bba_pkg::OP_FREE)
            begin
                word_reg <= WADDR_W'(q_prod >> Q_SH);
            end
            else
            begin
                word_reg <= sel_word;
            end
        end
        if (state_reg == bba_pkg::S_READ)
        begin
            base_reg <= XW'(word_reg) * XW'(WORD_BITS);
        end
        if (proceed)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
            used_reg    <= count_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;
    assign used_total    = used_reg;

endmodule

[sv/bba_ram.sv]
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
